>>> rtl/cfa_pkg.sv
// Shared types and constants for the frustum box culling block.
package cfa_pkg;

  localparam int COORD_W        = 16;
  localparam int HALF_W         = COORD_W - 1;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int SUM_W          = PROD_W + 2;
  localparam int D_SHIFT        = 14;
  localparam int PLANE_W        = 4 * COORD_W;
  localparam int CFG_IDX_W      = 3;
  localparam int PLANE_REGS     = 6;
  localparam int PLANE_SLOTS    = 8;
  localparam int PLANE_COUNT_DEF = 6;

  // register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_NEAR   = 3'd0,
    REG_PLANE_FAR    = 3'd1,
    REG_PLANE_LEFT   = 3'd2,
    REG_PLANE_RIGHT  = 3'd3,
    REG_PLANE_TOP    = 3'd4,
    REG_PLANE_BOTTOM = 3'd5
  } cfg_reg_t;

  // a, b, c in Q2.14, d in Q8.8
  typedef struct packed {
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] c;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] a;
  } plane_t;

  // box after the input register: centre and half extents
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [HALF_W-1:0]         hx;
    logic [HALF_W-1:0]         hy;
    logic [HALF_W-1:0]         hz;
  } box_t;

endpackage

>>> rtl/cfa_box_if.sv
// Box transaction channel: centre and full extents in Q8.8.
interface cfa_box_if import cfa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [COORD_W-1:0]        size_x;
  logic [COORD_W-1:0]        size_y;
  logic [COORD_W-1:0]        size_z;

  modport source (output valid, center_x, center_y, center_z, size_x, size_y, size_z,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, size_x, size_y, size_z,
                  output ready);
endinterface

>>> rtl/cfa_res_if.sv
// Result transaction channel: one inside flag per box.
interface cfa_res_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink   (input valid, inside_res, output ready);
endinterface

>>> rtl/cfa_cfg_if.sv
// Configuration write channel: register index and write data.
interface cfa_cfg_if import cfa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [PLANE_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/cfa_plane_regs.sv
// Plane register file written through the configuration port.
module cfa_plane_regs import cfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  cfa_cfg_if.sink    cfg,
  output plane_t     planes [PLANE_REGS]
);

  plane_t plane_r [PLANE_REGS];

  assign cfg.ready = 1'b1;

  // writes beyond the last plane register fall away
  always_ff @(posedge clk) begin
    for (int i = 0; i < PLANE_REGS; i++) begin
      if (!rst_n) begin
        plane_r[i] <= '0;
      end else if (cfg.valid && cfg.index == CFG_IDX_W'(i)
                   && cfg.index <= REG_PLANE_BOTTOM) begin
        plane_r[i] <= cfg.data;
      end
    end
  end

  assign planes = plane_r;

endmodule

>>> rtl/cfa_plane_lane.sv
// One plane lane: products registered, then the largest-corner test.
module cfa_plane_lane import cfa_pkg::*; (
  input  logic   clk,
  input  logic   adv,
  input  plane_t plane,
  input  box_t   box,
  output logic   cull
);

  logic signed [PROD_W-1:0] pcx_nxt, pcy_nxt, pcz_nxt;
  logic signed [PROD_W-1:0] phx_nxt, phy_nxt, phz_nxt;
  logic signed [PROD_W-1:0] hx_raw, hy_raw, hz_raw;
  logic signed [PROD_W-1:0] pcx_r, pcy_r, pcz_r;
  logic signed [PROD_W-1:0] phx_r, phy_r, phz_r;
  logic signed [SUM_W-1:0]  t_cx, t_cy, t_cz, t_hx, t_hy, t_hz, t_d;
  logic signed [SUM_W-1:0]  sum;

  // the corner with the largest value sits at centre + sign(n)*half on each axis,
  // so the maximum is n.centre + |a|hx + |b|hy + |c|hz + d
  always_comb begin
    pcx_nxt = plane.a * box.cx;
    pcy_nxt = plane.b * box.cy;
    pcz_nxt = plane.c * box.cz;
    hx_raw  = plane.a * $signed({1'b0, box.hx});
    hy_raw  = plane.b * $signed({1'b0, box.hy});
    hz_raw  = plane.c * $signed({1'b0, box.hz});
    phx_nxt = hx_raw[PROD_W-1] ? -hx_raw : hx_raw;
    phy_nxt = hy_raw[PROD_W-1] ? -hy_raw : hy_raw;
    phz_nxt = hz_raw[PROD_W-1] ? -hz_raw : hz_raw;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pcx_r <= pcx_nxt;
      pcy_r <= pcy_nxt;
      pcz_r <= pcz_nxt;
      phx_r <= phx_nxt;
      phy_r <= phy_nxt;
      phz_r <= phz_nxt;
    end
  end

  always_comb begin
    t_cx = SUM_W'(pcx_r);
    t_cy = SUM_W'(pcy_r);
    t_cz = SUM_W'(pcz_r);
    t_hx = SUM_W'(phx_r);
    t_hy = SUM_W'(phy_r);
    t_hz = SUM_W'(phz_r);
    // d is Q8.8, products are Q10.22
    t_d  = {{(SUM_W-COORD_W-D_SHIFT){plane.d[COORD_W-1]}}, plane.d, {D_SHIFT{1'b0}}};
    sum  = t_cx + t_cy + t_cz + t_hx + t_hy + t_hz + t_d;
  end

  // culled only if even the largest corner value is strictly negative
  assign cull = sum[SUM_W-1];

endmodule

>>> rtl/frustum_aabb_cull_top.sv
// Frustum box culling: one axis-aligned box per cycle is tested against up to
// PLANE_COUNT clip planes and reported inside or culled. A new box is taken every
// cycle while the result side keeps up; each box passes through the input register,
// the per-plane product register (six 16x16 multipliers per plane) and the result
// register before its result appears. Planes beyond the six registers never cull.
// Planes must be written by the user through the configuration port while no box
// is in flight; the block itself does not enforce it.
module frustum_aabb_cull_top import cfa_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cfa_box_if.sink   in_box,
  cfa_res_if.source out_res,
  cfa_cfg_if.sink   cfg_wr
);

  plane_t                 planes [PLANE_REGS];
  box_t                   box_r;
  logic                   s1_vld_r, s2_vld_r, out_vld_r, inside_r;
  logic                   adv;
  logic [PLANE_COUNT-1:0] cull;

  cfa_plane_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_wr),
    .planes (planes)
  );

  // the whole pipe moves whenever the result register is free or being taken
  assign adv          = !out_vld_r || out_res.ready;
  assign in_box.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_box.valid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      box_r.cx <= in_box.center_x;
      box_r.cy <= in_box.center_y;
      box_r.cz <= in_box.center_z;
      box_r.hx <= in_box.size_x[COORD_W-1:1];
      box_r.hy <= in_box.size_y[COORD_W-1:1];
      box_r.hz <= in_box.size_z[COORD_W-1:1];
      inside_r <= ~|cull;
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
    if (p < PLANE_REGS) begin : g_reg
      cfa_plane_lane u_lane (
        .clk   (clk),
        .adv   (adv),
        .plane (planes[p]),
        .box   (box_r),
        .cull  (cull[p])
      );
    end else begin : g_none
      assign cull[p] = 1'b0;
    end
  end

  assign out_res.valid      = out_vld_r;
  assign out_res.inside_res = inside_r;

  a_accept_moves_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    in_box.valid && in_box.ready |=> s1_vld_r)
    else $error("accepted box did not enter the input stage");

  a_stage_feeds_result: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && adv |=> out_vld_r)
    else $error("product stage transaction lost before the result register");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_vld_r) && $stable(s2_vld_r) && $stable(inside_r))
    else $error("pipeline moved while the result side stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s1_vld_r && !s2_vld_r && !out_vld_r)
    else $error("pipeline not empty after reset");

endmodule

>>> dv/frustum_aabb_cull_top_tb.sv
// Testbench for frustum_aabb_cull_top: directed and random boxes checked against a plane predictor.
module frustum_aabb_cull_top_tb import cfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PLANE_COUNT   = PLANE_COUNT_DEF;
  localparam int ONE_Q2_14     = 1 << D_SHIFT;
  localparam int ONE_Q8_8      = 256;
  localparam int EDGE          = 16 * ONE_Q8_8;   // half width of the test cube
  localparam int FAR_OFF       = 2 * EDGE;
  localparam int COORD_MIN     = -(1 << (COORD_W - 1));
  localparam int COORD_MAX     = (1 << (COORD_W - 1)) - 1;
  localparam int SIZE_MAX      = (1 << COORD_W) - 1;

  typedef enum int {
    STYLE_ZERO, STYLE_CUBE, STYLE_MAX, STYLE_MIN, STYLE_FRUSTUM, STYLE_RANDOM
  } plane_style_t;

  typedef struct {
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic [COORD_W-1:0]        sx, sy, sz;
  } box_item_t;

  typedef struct {
    int unsigned seq;
    bit          in_view;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cfa_box_if in_box ();
  cfa_res_if out_res ();
  cfa_cfg_if cfg_wr ();

  frustum_aabb_cull_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_box  (in_box),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  plane_t      plane_regs [PLANE_SLOTS];
  verdict_t    pending_verdicts [$];
  int unsigned boxes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned inside_seen = 0;
  int unsigned culled_seen = 0;
  int unsigned settings_applied = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_left = 0;

  always #CLK_HALF clk = ~clk;

  initial begin
    in_box.valid    = 1'b0;
    in_box.center_x = '0;
    in_box.center_y = '0;
    in_box.center_z = '0;
    in_box.size_x   = '0;
    in_box.size_y   = '0;
    in_box.size_z   = '0;
    out_res.ready   = 1'b0;
    cfg_wr.valid    = 1'b0;
    cfg_wr.index    = '0;
    cfg_wr.data     = '0;
    for (int i = 0; i < PLANE_SLOTS; i++) plane_regs[i] = '0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("frustum_aabb_cull_top verification failed");
      $finish;
    end
  end

  task automatic report(string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // a box is culled when some plane is strictly negative at all eight corners
  function automatic bit cull_verdict(box_item_t bx);
    longint cx, cy, cz, hx, hy, hz, x, y, z, v;
    plane_t pl;
    bit     all_neg;
    bit     in_view;
    cx = longint'($signed(bx.cx));
    cy = longint'($signed(bx.cy));
    cz = longint'($signed(bx.cz));
    hx = longint'(bx.sx >> 1);
    hy = longint'(bx.sy >> 1);
    hz = longint'(bx.sz >> 1);
    in_view = 1'b1;
    for (int p = 0; p < PLANE_COUNT && p < PLANE_SLOTS; p++) begin
      pl = plane_regs[p];
      all_neg = 1'b1;
      for (int k = 0; k < 8; k++) begin
        x = k[0] ? cx + hx : cx - hx;
        y = k[1] ? cy + hy : cy - hy;
        z = k[2] ? cz + hz : cz - hz;
        v = longint'($signed(pl.a)) * x + longint'($signed(pl.b)) * y
          + longint'($signed(pl.c)) * z + (longint'($signed(pl.d)) <<< D_SHIFT);
        if (v >= 0) all_neg = 1'b0;
      end
      if (all_neg) in_view = 1'b0;
    end
    return in_view;
  endfunction

  function automatic box_item_t make_box(int cx, int cy, int cz, int sx, int sy, int sz);
    box_item_t bx;
    bx.cx = COORD_W'(cx);
    bx.cy = COORD_W'(cy);
    bx.cz = COORD_W'(cz);
    bx.sx = COORD_W'(sx);
    bx.sy = COORD_W'(sy);
    bx.sz = COORD_W'(sz);
    return bx;
  endfunction

  function automatic plane_t make_plane(int a, int b, int c, int d);
    plane_t pl;
    pl.a = COORD_W'(a);
    pl.b = COORD_W'(b);
    pl.c = COORD_W'(c);
    pl.d = COORD_W'(d);
    return pl;
  endfunction

  function automatic int pick_extreme(bit is_size);
    case ($urandom_range(3))
      0: return is_size ? 0 : COORD_MIN;
      1: return is_size ? SIZE_MAX : COORD_MAX;
      2: return is_size ? 1 : 0;
      default: return is_size ? SIZE_MAX - 1 : -1;
    endcase
  endfunction

  function automatic box_item_t random_box();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // near the cube, where results are mixed
      return make_box(int'($urandom_range(6 * EDGE)) - 3 * EDGE,
                      int'($urandom_range(6 * EDGE)) - 3 * EDGE,
                      int'($urandom_range(6 * EDGE)) - 3 * EDGE,
                      $urandom_range(EDGE), $urandom_range(EDGE), $urandom_range(EDGE));
    end else if (pick < 85) begin
      return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      return make_box(pick_extreme(0), pick_extreme(0), pick_extreme(0),
                      pick_extreme(1), pick_extreme(1), pick_extreme(1));
    end
  endfunction

  // drive one box and wait for the transaction
  task automatic send_box(box_item_t bx);
    verdict_t vd;
    @(negedge clk);
    in_box.center_x = bx.cx;
    in_box.center_y = bx.cy;
    in_box.center_z = bx.cz;
    in_box.size_x   = bx.sx;
    in_box.size_y   = bx.sy;
    in_box.size_z   = bx.sz;
    in_box.valid    = 1'b1;
    do @(posedge clk); while (!in_box.ready);
    vd.seq     = boxes_sent;
    vd.in_view = cull_verdict(bx);
    pending_verdicts.push_back(vd);
    boxes_sent++;
  endtask

  task automatic sender_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      in_box.valid = 1'b0;
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_box.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, plane_t value);
    @(negedge clk);
    cfg_wr.index = idx;
    cfg_wr.data  = value;
    cfg_wr.valid = 1'b1;
    do @(posedge clk); while (!cfg_wr.ready);
    if (idx < PLANE_REGS) plane_regs[idx] = value;
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  task automatic program_planes(plane_style_t style);
    plane_t   set_planes [PLANE_REGS];
    cfg_reg_t r;
    wait_drain();
    set_planes[REG_PLANE_NEAR]   = make_plane(0, 0, ONE_Q2_14, EDGE / ONE_Q8_8 * ONE_Q8_8);
    set_planes[REG_PLANE_FAR]    = make_plane(0, 0, -ONE_Q2_14, EDGE);
    set_planes[REG_PLANE_LEFT]   = make_plane(ONE_Q2_14, 0, 0, EDGE);
    set_planes[REG_PLANE_RIGHT]  = make_plane(-ONE_Q2_14, 0, 0, EDGE);
    set_planes[REG_PLANE_TOP]    = make_plane(0, -ONE_Q2_14, 0, EDGE);
    set_planes[REG_PLANE_BOTTOM] = make_plane(0, ONE_Q2_14, 0, EDGE);
    for (int i = 0; i < PLANE_REGS; i++) begin
      case (style)
        STYLE_ZERO:    set_planes[i] = '0;
        STYLE_MAX:     set_planes[i] = make_plane(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        STYLE_MIN:     set_planes[i] = make_plane(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        STYLE_FRUSTUM: set_planes[i] = make_plane(int'($urandom_range(2 * ONE_Q2_14)) - ONE_Q2_14,
                                                  int'($urandom_range(2 * ONE_Q2_14)) - ONE_Q2_14,
                                                  int'($urandom_range(2 * ONE_Q2_14)) - ONE_Q2_14,
                                                  int'($urandom_range(3 * EDGE)) - EDGE);
        STYLE_RANDOM:  set_planes[i] = plane_t'({$urandom, $urandom});
        default: ;
      endcase
    end
    r = r.first();
    do begin
      cfg_write(r, set_planes[r]);
      r = r.next();
    end while (r != r.first());
    settings_applied++;
  endtask

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_res.ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_res.ready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    verdict_t vd;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (pending_verdicts.size() == 0) begin
        report($sformatf("unexpected result, inside_res=%0b", out_res.inside_res));
      end else begin
        vd = pending_verdicts.pop_front();
        results_checked++;
        if (vd.in_view) inside_seen++;
        else culled_seen++;
        if (out_res.inside_res !== vd.in_view)
          report($sformatf("box %0d: inside_res %0b, expected %0b", vd.seq,
                           out_res.inside_res, vd.in_view));
      end
    end
  end

  // planes all zero after reset, so nothing may be culled
  task automatic test_reset_state();
    send_box(make_box(0, 0, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
    send_box(make_box(COORD_MAX, COORD_MIN, COORD_MAX, SIZE_MAX, 1, SIZE_MAX));
    wait_drain();
  endtask

  task automatic test_cube_cases();
    program_planes(STYLE_CUBE);
    send_box(make_box(0, 0, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    // one box beyond each face
    send_box(make_box(-FAR_OFF, 0, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(FAR_OFF, 0, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(0, FAR_OFF, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(0, -FAR_OFF, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(0, 0, -FAR_OFF, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(0, 0, FAR_OFF, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    // corner lands exactly on the left plane
    send_box(make_box(-EDGE - 1024, 0, 0, 2048, ONE_Q8_8, ONE_Q8_8));
    // odd widths: floor of the half decides
    send_box(make_box(-EDGE - 2, 0, 0, 3, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(-EDGE - 2, 0, 0, 5, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(-EDGE, 0, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    send_box(make_box(COORD_MIN, COORD_MIN, COORD_MIN, 0, 0, 0));
    send_box(make_box(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
    send_box(make_box(0, 0, 0, SIZE_MAX, SIZE_MAX, SIZE_MAX));
    wait_drain();
  endtask

  // a zero plane and writes past the register map must not cull
  task automatic test_unmapped_and_zero_plane();
    plane_t cull_all;
    cull_all = make_plane(0, 0, 0, COORD_MIN);
    cfg_write(CFG_IDX_W'(PLANE_REGS), cull_all);
    cfg_write(CFG_IDX_W'(PLANE_SLOTS - 1), cull_all);
    send_box(make_box(0, 0, 0, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    wait_drain();
    cfg_write(REG_PLANE_NEAR, '0);
    send_box(make_box(0, 0, -FAR_OFF, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    send_box(make_box(0, 0, FAR_OFF, ONE_Q8_8, ONE_Q8_8, ONE_Q8_8));
    wait_drain();
  endtask

  task automatic test_backpressure();
    program_planes(STYLE_CUBE);
    rx_stall_pct = 0;
    @(posedge clk);
    rx_hold_left = 150;
    for (int i = 0; i < 40; i++) send_box(random_box());
    // sender now waits for every outstanding result before going on
    wait_drain();
    for (int i = 0; i < 10; i++) send_box(random_box());
    wait_drain();
  endtask

  task automatic run_phase(int count, int tx_pct, int rx_pct);
    rx_stall_pct = rx_pct;
    for (int i = 0; i < count; i++) begin
      send_box(random_box());
      sender_gap(tx_pct);
    end
    wait_drain();
    rx_stall_pct = 0;
  endtask

  task automatic test_random_traffic();
    program_planes(STYLE_CUBE);
    run_phase(200, 0, 0);
    program_planes(STYLE_FRUSTUM);
    run_phase(200, 65, 0);
    program_planes(STYLE_MAX);
    run_phase(150, 0, 65);
    program_planes(STYLE_MIN);
    run_phase(150, 8, 8);
    program_planes(STYLE_RANDOM);
    run_phase(150, 65, 65);
    program_planes(STYLE_FRUSTUM);
    run_phase(150, 0, 0);
    program_planes(STYLE_ZERO);
    run_phase(50, 8, 8);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_cube_cases();
    test_unmapped_and_zero_plane();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    $display("Covered %0d boxes (%0d inside, %0d culled) over %0d plane settings,",
             results_checked, inside_seen, culled_seen, settings_applied);
    $display("with sender gaps, result stalls and a long hold-off; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("frustum_aabb_cull_top verification clean");
    end else begin
      $display("frustum_aabb_cull_top verification failed");
    end
    $finish;
  end

endmodule
